### design/ept_pkg.sv
// Package: payload types, CORDIC constants and shared helpers for the pose transform.
package ept_pkg;

  localparam int NumIter = 16;
  localparam logic signed [15:0] AngMax = 16'sd25736;
  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [19:0] PiQ16 = 20'sd205887;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] rx_angle;
    logic signed [15:0] ry_angle;
    logic signed [15:0] rz_angle;
  } ept_in_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r20;
    logic signed [15:0] r01;
    logic signed [15:0] r11;
    logic signed [15:0] r21;
    logic signed [15:0] r02;
    logic signed [15:0] r12;
    logic signed [15:0] r22;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } ept_out_t;

  // One rotation in flight: x, y in Q.30, residual angle z in Q16.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [19:0] z;
    logic               neg;
  } ept_rot_t;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0: atan_q16 = 20'sd51472;
      4'd1: atan_q16 = 20'sd30386;
      4'd2: atan_q16 = 20'sd16055;
      4'd3: atan_q16 = 20'sd8150;
      4'd4: atan_q16 = 20'sd4091;
      4'd5: atan_q16 = 20'sd2047;
      4'd6: atan_q16 = 20'sd1024;
      4'd7: atan_q16 = 20'sd512;
      4'd8: atan_q16 = 20'sd256;
      4'd9: atan_q16 = 20'sd128;
      4'd10: atan_q16 = 20'sd64;
      4'd11: atan_q16 = 20'sd32;
      4'd12: atan_q16 = 20'sd16;
      4'd13: atan_q16 = 20'sd8;
      4'd14: atan_q16 = 20'sd4;
      default: atan_q16 = 20'sd2;
    endcase
  endfunction

  // Clamp to plus or minus one in Q1.14.
  function automatic logic signed [15:0] clamp_unit(input logic signed [47:0] v);
    if (v > 48'sd16384) clamp_unit = 16'sd16384;
    else if (v < -48'sd16384) clamp_unit = -16'sd16384;
    else clamp_unit = v[15:0];
  endfunction

  // Saturate, scale to Q16 and fold into the right half plane.
  function automatic ept_rot_t fold_angle(input logic signed [15:0] a);
    logic signed [15:0] s;
    logic signed [19:0] z;
    ept_rot_t r;
    s = a;
    if (a > AngMax) s = AngMax;
    if (a < -AngMax) s = -AngMax;
    z = {s[15], s, 3'b000};
    r.neg = 1'b0;
    if (z > HalfPiQ16) begin
      z = z - PiQ16;
      r.neg = 1'b1;
    end else if (z < -HalfPiQ16) begin
      z = z + PiQ16;
      r.neg = 1'b1;
    end
    r.x = GainQ30;
    r.y = '0;
    r.z = z;
    fold_angle = r;
  endfunction

endpackage

### design/euler_pose_to_homogeneous_transform.sv
// Top level: Euler pose to rotation matrix plus translation, fully pipelined.
// Pipeline: 1 fold stage + 16 CORDIC cells + 3 matrix stages from start to out_valid.
// Throughput: one request per cycle; busy is held low, the pipeline never stalls.
// The depth is set by the chain of sixteen CORDIC cells, one shift per cell.
// Reset clears only the valid shift line; payload stages carry no reset.
// The receiver cannot stall: a result shows for exactly one cycle.
module euler_pose_to_homogeneous_transform (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ept_pkg::ept_in_t   in_data,
  output logic               out_valid,
  output ept_pkg::ept_out_t  out_data
);
  import ept_pkg::*;

  localparam int Depth = NumIter + 4;

  // Fold stage registers.
  ept_rot_t fa_r, fb_r, fc_r;
  ept_rot_t ca_w [NumIter+1];
  ept_rot_t cb_w [NumIter+1];
  ept_rot_t cc_w [NumIter+1];

  logic [Depth-1:0] vld_r, vld_nxt;
  logic [95:0]      pos_r [Depth];
  logic             accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Saturate and fold each angle on entry.
  always_ff @(posedge clk) begin
    fa_r <= fold_angle(in_data.rx_angle);
    fb_r <= fold_angle(in_data.ry_angle);
    fc_r <= fold_angle(in_data.rz_angle);
  end

  assign ca_w[0] = fa_r;
  assign cb_w[0] = fb_r;
  assign cc_w[0] = fc_r;

  // Chain of CORDIC cells, each handing its rotation to the next every cycle.
  for (genvar g = 0; g < NumIter; g++) begin : g_cell
    ept_cordic_cell u_cell (
      .clk   (clk),
      .shift (4'(g)),
      .a_in  (ca_w[g]),
      .b_in  (cb_w[g]),
      .c_in  (cc_w[g]),
      .a_out (ca_w[g+1]),
      .b_out (cb_w[g+1]),
      .c_out (cc_w[g+1])
    );
  end

  ept_matrix u_matrix (
    .clk  (clk),
    .a_in (ca_w[NumIter]),
    .b_in (cb_w[NumIter]),
    .c_in (cc_w[NumIter]),
    .r00  (out_data.r00),
    .r10  (out_data.r10),
    .r20  (out_data.r20),
    .r01  (out_data.r01),
    .r11  (out_data.r11),
    .r21  (out_data.r21),
    .r02  (out_data.r02),
    .r12  (out_data.r12),
    .r22  (out_data.r22)
  );

  // Carry the position alongside the angles.
  always_ff @(posedge clk) begin
    pos_r[0] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
    for (int i = 1; i < Depth; i++) begin
      pos_r[i] <= pos_r[i-1];
    end
  end

  assign out_data.tx = pos_r[Depth-1][95:64];
  assign out_data.ty = pos_r[Depth-1][63:32];
  assign out_data.tz = pos_r[Depth-1][31:0];

  // Advance the valid line one stage a cycle.
  always_comb begin
    vld_nxt = {vld_r[Depth-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[Depth-1];
endmodule

### design/ept_cordic_cell.sv
// One CORDIC cell: three micro-rotations of a fixed shift, registered.
module ept_cordic_cell (
  input  logic               clk,
  input  logic [3:0]         shift,
  input  ept_pkg::ept_rot_t  a_in,
  input  ept_pkg::ept_rot_t  b_in,
  input  ept_pkg::ept_rot_t  c_in,
  output ept_pkg::ept_rot_t  a_out,
  output ept_pkg::ept_rot_t  b_out,
  output ept_pkg::ept_rot_t  c_out
);
  import ept_pkg::*;

  ept_rot_t a_nxt, b_nxt, c_nxt;
  ept_rot_t a_r, b_r, c_r;

  function automatic ept_rot_t rotate(input ept_rot_t v, input logic [3:0] sh);
    ept_rot_t o;
    logic signed [33:0] xs, ys;
    xs = v.x >>> sh;
    ys = v.y >>> sh;
    o = v;
    if (!v.z[19]) begin
      o.x = v.x - ys;
      o.y = v.y + xs;
      o.z = v.z - atan_q16(sh);
    end else begin
      o.x = v.x + ys;
      o.y = v.y - xs;
      o.z = v.z + atan_q16(sh);
    end
    rotate = o;
  endfunction

  always_comb begin
    a_nxt = rotate(a_in, shift);
    b_nxt = rotate(b_in, shift);
    c_nxt = rotate(c_in, shift);
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
  end

  assign a_out = a_r;
  assign b_out = b_r;
  assign c_out = c_r;
endmodule

### design/ept_matrix.sv
// Matrix stage: rounds sines and cosines, forms the nine entries over three registered steps.
module ept_matrix (
  input  logic              clk,
  input  ept_pkg::ept_rot_t a_in,
  input  ept_pkg::ept_rot_t b_in,
  input  ept_pkg::ept_rot_t c_in,
  output logic signed [15:0] r00,
  output logic signed [15:0] r10,
  output logic signed [15:0] r20,
  output logic signed [15:0] r01,
  output logic signed [15:0] r11,
  output logic signed [15:0] r21,
  output logic signed [15:0] r02,
  output logic signed [15:0] r12,
  output logic signed [15:0] r22
);
  import ept_pkg::*;

  logic signed [15:0] sa_r, ca_r, sb_r, cb_r, sc_r, cc_r;
  logic signed [15:0] sa_d_r, ca_d_r, sb_d_r;
  logic signed [31:0] sbcc_r, sbsc_r, cbcc_r, cbsc_r, sacb_r, cacb_r;
  logic signed [31:0] casc_r, sasc_r, cacc_r, sacc_r;
  logic signed [15:0] sb_e_r;
  logic signed [15:0] r00_r, r10_r, r20_r, r01_r, r11_r, r21_r, r12_r, r22_r;
  logic signed [47:0] p10, p20, p11, p21;

  function automatic logic signed [15:0] round_sc(input logic signed [33:0] v,
                                                  input logic neg);
    logic signed [33:0] t;
    logic signed [15:0] u;
    t = (v + 34'sd32768) >>> 16;
    u = clamp_unit({{14{t[33]}}, t});
    round_sc = neg ? -u : u;
  endfunction

  function automatic logic signed [15:0] entry(input logic signed [47:0] q42);
    logic signed [47:0] t;
    t = (q42 + 48'sd134217728) >>> 28;
    entry = clamp_unit(t);
  endfunction

  function automatic logic signed [47:0] up14(input logic signed [31:0] p);
    up14 = {{2{p[31]}}, p, 14'b0};
  endfunction

  // Round CORDIC outputs to Q1.14.
  always_ff @(posedge clk) begin
    sa_r <= round_sc(a_in.y, a_in.neg);
    ca_r <= round_sc(a_in.x, a_in.neg);
    sb_r <= round_sc(b_in.y, b_in.neg);
    cb_r <= round_sc(b_in.x, b_in.neg);
    sc_r <= round_sc(c_in.y, c_in.neg);
    cc_r <= round_sc(c_in.x, c_in.neg);
  end

  // Pair products.
  always_ff @(posedge clk) begin
    sbcc_r <= sb_r * cc_r;
    sbsc_r <= sb_r * sc_r;
    cbcc_r <= cb_r * cc_r;
    cbsc_r <= cb_r * sc_r;
    sacb_r <= sa_r * cb_r;
    cacb_r <= ca_r * cb_r;
    casc_r <= ca_r * sc_r;
    sasc_r <= sa_r * sc_r;
    cacc_r <= ca_r * cc_r;
    sacc_r <= sa_r * cc_r;
    sa_d_r <= sa_r;
    ca_d_r <= ca_r;
    sb_d_r <= sb_r;
  end

  // Triple products plus scaled pairs, rounded once.
  always_comb begin
    p10 = sa_d_r * sbcc_r + up14(casc_r);
    p20 = -(ca_d_r * sbcc_r) + up14(sasc_r);
    p11 = -(sa_d_r * sbsc_r) + up14(cacc_r);
    p21 = ca_d_r * sbsc_r + up14(sacc_r);
  end

  always_ff @(posedge clk) begin
    r00_r <= entry(up14(cbcc_r));
    r10_r <= entry(p10);
    r20_r <= entry(p20);
    r01_r <= entry(-up14(cbsc_r));
    r11_r <= entry(p11);
    r21_r <= entry(p21);
    sb_e_r <= sb_d_r;
    r12_r <= entry(-up14(sacb_r));
    r22_r <= entry(up14(cacb_r));
  end

  assign r00 = r00_r;
  assign r10 = r10_r;
  assign r20 = r20_r;
  assign r01 = r01_r;
  assign r11 = r11_r;
  assign r21 = r21_r;
  assign r02 = sb_e_r;
  assign r12 = r12_r;
  assign r22 = r22_r;
endmodule
